// ===== src/aliq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliq_pkg
// Shared constants for the aliquot sum block.
// ----------------------------------------------------------------------------
package aliq_pkg;

    localparam int SIEVE_LIMIT_DEF = 65536;
    localparam int NUMBER_BITS_DEF = 32;
    // prime count below the largest allowed sieve limit
    localparam int STORE_DEPTH     = 6542;
    localparam int PRIME_W         = 16;
    localparam int SUM_W           = 36;

endpackage

// ===== src/aliq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliq_div
// Radix-16 restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module aliq_div
    import aliq_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUMBER_BITS-1:0] i_dividend,
    input  logic [PRIME_W-1:0]     i_divisor,
    output logic                   o_done,
    output logic [NUMBER_BITS-1:0] o_quot,
    output logic [PRIME_W-1:0]     o_rem
);

    localparam int PW   = ((NUMBER_BITS + 3) / 4) * 4;
    localparam int ITER = PW / 4;
    localparam int TW   = $clog2(ITER + 1);

    logic [PW-1:0]      r_q, n_q;
    logic [PRIME_W-1:0] r_r, n_r;
    logic [PRIME_W-1:0] r_d;
    logic [TW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        logic [PRIME_W:0] t;
        n_q = r_q;
        n_r = r_r;
        for (int s = 0; s < 4; s++) begin
            t   = {n_r, n_q[PW-1]};
            n_q = {n_q[PW-2:0], 1'b0};
            if (t >= {1'b0, r_d}) begin
                t      = t - {1'b0, r_d};
                n_q[0] = 1'b1;
            end
            n_r = t[PRIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= PW'(i_dividend);
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= TW'(ITER);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_r   <= n_r;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == TW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[NUMBER_BITS-1:0];
    assign o_rem  = r_r;

endmodule

// ===== src/aliquot_sum_trial_division_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliquot_sum_trial_division_top
// Sum of proper divisors of a number by trial division over stored primes.
//
//   channel  direction  signals                               payload
//   in       request in i_in_valid / o_in_stall               i_number
//   out      result out o_out_valid / i_out_stall             o_proper_divisor_sum
//
// After reset the block builds its prime table: a clear of the sieve bits,
// the marking pass, and a scan that reads and tests each candidate;
// o_in_stall stays high until then. One request then tries the stored
// primes in turn, dividing by each on the shared divider and again on the
// quotient for each prime that divides, with o_in_stall high meanwhile;
// a prime input near 2^32 is the slowest case, typical inputs far faster.
// A waiting result does not block a new request.
// ----------------------------------------------------------------------------
module aliquot_sum_trial_division_top
    import aliq_pkg::*;
#(
    parameter int SIEVE_LIMIT = SIEVE_LIMIT_DEF,
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [NUMBER_BITS-1:0] i_number,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SUM_W-1:0]       o_proper_divisor_sum
);

    localparam int LW = $clog2(SIEVE_LIMIT);
    localparam int KW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [LW:0] LIM = (LW + 1)'(SIEVE_LIMIT);

    typedef enum logic [3:0] {
        S_CLR, S_SV_RD, S_SV_TST, S_SV_MARK, S_SC_RD, S_SC_TST,
        S_IDLE, S_FETCH, S_SQ, S_CHK, S_DIV, S_MULA, S_MULB, S_FINAL, S_DONE
    } t_state;

    t_state r_state;

    // sieve bits and prime table
    logic                r_comp [SIEVE_LIMIT];
    logic [PRIME_W-1:0]  r_store [STORE_DEPTH];
    logic                r_bit;
    logic [PRIME_W-1:0]  r_rd;

    logic [LW:0]         r_a, r_i, r_j;
    logic [CW-1:0]       r_count, r_k;

    logic [NUMBER_BITS-1:0] r_n, r_rest;
    logic [PRIME_W-1:0]     r_p;
    logic [2*PRIME_W-1:0]   r_sq;
    logic [SUM_W-1:0]       r_prod, r_term, r_acc, r_sum;
    logic                   r_final, r_out_valid;

    logic [LW-1:0]          bit_addr;
    logic                   bit_we, bit_wd;
    logic [KW-1:0]          st_addr;
    logic                   st_we;
    logic [2*LW+1:0]        sq_i;
    logic [LW:0]            j_next;

    logic                   div_start, div_done;
    logic [NUMBER_BITS-1:0] div_dvd, div_quot;
    logic [PRIME_W-1:0]     div_rem;
    logic                   too_big;

    assign sq_i    = (2*LW+2)'(r_i) * (2*LW+2)'(r_i);
    assign j_next  = r_j + r_i;
    assign too_big = r_sq > (2*PRIME_W)'(r_rest);

    always_comb begin
        bit_addr = r_a[LW-1:0];
        bit_we   = 1'b0;
        bit_wd   = 1'b0;
        case (r_state)
            S_CLR:     bit_we = 1'b1;
            S_SV_RD:   bit_addr = r_i[LW-1:0];
            S_SV_MARK: begin
                bit_addr = r_j[LW-1:0];
                bit_we   = 1'b1;
                bit_wd   = 1'b1;
            end
            default:   bit_addr = r_a[LW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bit_we) r_comp[bit_addr] <= bit_wd;
        r_bit <= r_comp[bit_addr];
    end

    assign st_we   = (r_state == S_SC_TST) && !r_bit && (r_count < CW'(STORE_DEPTH));
    assign st_addr = (r_state == S_SC_TST) ? r_count[KW-1:0] : r_k[KW-1:0];

    always_ff @(posedge i_clk) begin
        if (st_we) r_store[st_addr] <= PRIME_W'(r_a);
        r_rd <= r_store[st_addr];
    end

    // new division on a fresh prime, or again on the quotient after a hit
    assign div_start = ((r_state == S_CHK) && !too_big)
                    || ((r_state == S_DIV) && div_done && (div_rem == '0));
    assign div_dvd   = (r_state == S_DIV) ? div_quot : r_rest;

    aliq_div #(.NUMBER_BITS(NUMBER_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_p),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_a         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, or drop the one just taken
            if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_a <= r_a + 1'b1;
                    if (r_a == LIM - 1'b1) begin
                        r_i     <= (LW + 1)'(2);
                        r_state <= S_SV_RD;
                    end
                end
                S_SV_RD: r_state <= S_SV_TST;
                S_SV_TST: begin
                    if (sq_i >= (2*LW+2)'(LIM)) begin
                        r_a     <= (LW + 1)'(2);
                        r_state <= S_SC_RD;
                    end else if (!r_bit) begin
                        r_j     <= sq_i[LW:0];
                        r_state <= S_SV_MARK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SV_RD;
                    end
                end
                S_SV_MARK: begin
                    r_j <= j_next;
                    if (j_next >= LIM) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SV_RD;
                    end
                end
                S_SC_RD: r_state <= S_SC_TST;
                S_SC_TST: begin
                    if (st_we) r_count <= r_count + 1'b1;
                    if (r_a == LIM - 1'b1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_a     <= r_a + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_n     <= i_number;
                        r_rest  <= i_number;
                        r_k     <= '0;
                        r_final <= 1'b0;
                        // zero gives zero: empty product and no cofactor
                        r_prod  <= (i_number == '0) ? '0 : SUM_W'(1);
                        r_state <= (i_number == '0) ? S_FINAL : S_FETCH;
                    end
                end
                S_FETCH: r_state <= (r_k >= r_count) ? S_FINAL : S_SQ;
                S_SQ: begin
                    r_p     <= r_rd;
                    r_sq    <= (2*PRIME_W)'(r_rd) * (2*PRIME_W)'(r_rd);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_term  <= SUM_W'(1);
                    r_state <= too_big ? S_FINAL : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_rem == '0) begin
                            r_rest <= div_quot;
                            r_term <= r_term * SUM_W'(r_p) + SUM_W'(1);
                        end else if (r_term != SUM_W'(1)) begin
                            r_state <= S_MULA;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                // product times term mod 2^36, split on term halves
                S_MULA: begin
                    r_acc   <= r_prod * SUM_W'(r_term[17:0]);
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_prod  <= r_acc + {r_prod[17:0] * r_term[35:18], 18'b0};
                    r_k     <= r_k + 1'b1;
                    r_state <= r_final ? S_DONE : S_FETCH;
                end
                S_FINAL: begin
                    if (r_rest > NUMBER_BITS'(1)) begin
                        r_term  <= SUM_W'(r_rest) + SUM_W'(1);
                        r_final <= 1'b1;
                        r_state <= S_MULA;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_sum       <= r_prod - SUM_W'(r_n);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_proper_divisor_sum = r_sum;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside division state");

    a_prime_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_p >= PRIME_W'(2)))
        else $error("trial divisor below two");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STORE_DEPTH))
        else $error("prime count past table depth");

endmodule

// ===== tb/aliquot_sum_trial_division_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliquot_sum_trial_division_top_test
// Checks the proper divisor sum block against an independent prediction.
//
// A directed list covers one, small primes and powers, perfect numbers and
// the hard cases near 2^32. A random mix follows. Most numbers are smooth,
// so they factor fast; a few are semiprimes or full 32-bit values. The
// prediction builds its own prime table and factors each accepted request.
// Sender and receiver idle at random in two phases, then never. A watchdog
// ends the run if nothing is accepted for too long.
// ----------------------------------------------------------------------------
module aliquot_sum_trial_division_top_test;
    import aliq_pkg::*;

    localparam int NB = NUMBER_BITS_DEF;
    // startup and a prime near 2^32 are the slowest stretches, so allow margin
    localparam int WATCHDOG_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 50;
    localparam int RANDOM_ITEMS = 80;

    // ------------------------------------------------------------------------
    // Divisor sum predictor and the queue of sums still to arrive.
    // ------------------------------------------------------------------------
    class divisor_sum_board;
        bit [PRIME_W-1:0] primes[$];
        bit [SUM_W-1:0] sums_due[$];
        int mismatches;

        function new();
            bit composite[];
            composite = new[SIEVE_LIMIT_DEF];
            for (int i = 2; i < SIEVE_LIMIT_DEF; i++) begin
                if (!composite[i]) begin
                    primes.insert(primes.size(), i[PRIME_W-1:0]);
                    for (longint j = longint'(i) * i; j < SIEVE_LIMIT_DEF; j += i)
                        composite[j] = 1;
                end
            end
            mismatches = 0;
        endfunction

        function bit [SUM_W-1:0] sigma_less_n(bit [NB-1:0] number);
            longint unsigned rest, prod, p, term;
            rest = number;
            prod = 1;
            if (number == 0) return '0;
            foreach (primes[k]) begin
                p = primes[k];
                if (p * p > rest) break;
                if (rest % p == 0) begin
                    term = 1;
                    while (rest % p == 0) begin
                        rest = rest / p;
                        term = term * p + 1;
                    end
                    prod = prod * term;
                end
            end
            // leftover cofactor is a prime
            if (rest > 1) prod = prod * (rest + 1);
            return SUM_W'(prod - longint'(number));
        endfunction

        function void note_request(bit [NB-1:0] number);
            sums_due.insert(sums_due.size(), sigma_less_n(number));
        endfunction

        function void check_sum(bit [SUM_W-1:0] got);
            bit [SUM_W-1:0] want;
            if (sums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", got);
                return;
            end
            want = sums_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sum mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [NB-1:0] i_number;
    logic o_out_valid;
    logic i_out_stall;
    logic [SUM_W-1:0] o_proper_divisor_sum;

    divisor_sum_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    aliquot_sum_trial_division_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_number             (i_number),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_proper_divisor_sum (o_proper_divisor_sum)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // receiver stall pattern, changed only on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // request and result monitor plus the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_request(i_number);
            if (o_out_valid && !i_out_stall) board.check_sum(o_proper_divisor_sum);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_number(input logic [NB-1:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_number = n;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [NB-1:0] random_number();
        logic [NB-1:0] n;
        int pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            // full width: may end with a large prime cofactor, slow
            n = $urandom;
        end else if (pick < 20) begin
            // semiprime of two modest primes
            n = NB'(board.primes[$urandom_range(999)])
                * NB'(board.primes[$urandom_range(999)]);
        end else begin
            // smooth value pushed up through the high bits
            n = NB'($urandom_range(65535, 1)) << $urandom_range(16);
        end
        if (n == 0) n = 1;
        return n;
    endfunction

    initial begin
        logic [NB-1:0] directed[$];
        board = new();
        quiet_cycles = 0;
        send_idle_pct = 37;
        recv_idle_pct = 68;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_number = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one, small primes and powers, perfect numbers, edges of the range
        directed = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd28, 32'd496,
                     32'd8128, 32'd65521, 32'd65536, 32'd65537, 32'd720720,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFB,
                     32'd4293001441, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed[i]) send_number(directed[i]);
        i_in_valid = 1'b0;

        // hold off until every pending sum has come out
        while (board.sums_due.size() != 0) @(negedge i_clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                send_idle_pct = 68;
                recv_idle_pct = 37;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_number(random_number());
        end
        i_in_valid = 1'b0;

        while (board.sums_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/aliq_pkg.sv
src/aliq_div.sv
src/aliquot_sum_trial_division_top.sv
tb/aliquot_sum_trial_division_top_test.sv
